// ===== rtl/rbqs_pkg.sv =====
`default_nettype none
package rbqs_pkg;

    // histogram geometry
    localparam int MAX_POSITIONS  = 256;
    localparam int QUALITY_LEVELS = 64;
    localparam int COUNTER_BITS   = 32;
    localparam int NUCLEOTIDES    = 5;

    localparam int POS_W     = $clog2(MAX_POSITIONS);
    localparam int QUAL_W    = $clog2(QUALITY_LEVELS);
    localparam int ADDR_W    = 2 + POS_W + QUAL_W;
    localparam int HIST_ROWS = 2 ** ADDR_W;
    localparam int ROW_W     = NUCLEOTIDES * COUNTER_BITS;
    localparam int LANE_W    = 3;

    // per-read tallies must hold MAX_POSITIONS itself
    localparam int CNT_W   = $clog2(MAX_POSITIONS + 1);
    localparam int COUNT_W = 9;
    localparam int VALUE_W = 32;

    // signed quality score, char minus offset
    localparam int SCORE_W = 9;
    localparam logic signed [SCORE_W-1:0] Q20_LEVEL = 9'sd20;
    localparam logic signed [SCORE_W-1:0] Q30_LEVEL = 9'sd30;
    localparam logic signed [SCORE_W-1:0] QUAL_MAX_S = SCORE_W'(QUALITY_LEVELS - 1);

    localparam logic ACT_BASE  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic REPLY_COUNTS = 1'b0;
    localparam logic REPLY_HIST   = 1'b1;

    typedef enum logic [1:0] {
        CFG_QUALITY_OFFSET = 2'd0,
        CFG_QUALITY_CUTOFF = 2'd1,
        CFG_PAIRED_MODE    = 2'd2
    } cfg_index_t;

    typedef enum logic [LANE_W-1:0] {
        NUC_A     = 3'd0,
        NUC_C     = 3'd1,
        NUC_G     = 3'd2,
        NUC_T     = 3'd3,
        NUC_N     = 3'd4,
        NUC_OTHER = 3'd5
    } nuc_t;

    // histogram request issued at input accept
    typedef struct packed {
        logic              rd;
        logic              inc;
        logic [ADDR_W-1:0] addr;
        logic [LANE_W-1:0] lane;
    } hist_req_t;

    function automatic nuc_t nucleotide_code(input logic [7:0] c);
        nuc_t n;
        case (c)
            8'h41, 8'h61: n = NUC_A;  // A a
            8'h43, 8'h63: n = NUC_C;  // C c
            8'h47, 8'h67: n = NUC_G;  // G g
            8'h54, 8'h74: n = NUC_T;  // T t
            8'h4E, 8'h6E: n = NUC_N;  // N n
            default:      n = NUC_OTHER;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rbqs_hist.sv =====
`default_nettype none
module rbqs_hist (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire rbqs_pkg::hist_req_t               req,
    input  wire logic                              retire,
    output logic [rbqs_pkg::COUNTER_BITS-1:0]      lane_value,
    output logic                                   clearing
);

    localparam int CB = rbqs_pkg::COUNTER_BITS;

    // one row holds the five nucleotide counters of a mate/set/position/quality
    logic [rbqs_pkg::ROW_W-1:0] mem [rbqs_pkg::HIST_ROWS];

    logic [rbqs_pkg::ROW_W-1:0]  rd_data_reg;
    logic                        p_inc_reg;
    logic [rbqs_pkg::ADDR_W-1:0] p_addr_reg;
    logic [rbqs_pkg::LANE_W-1:0] p_lane_reg;

    logic                        wr_valid_reg;
    logic [rbqs_pkg::ADDR_W-1:0] wr_addr_reg;
    logic [rbqs_pkg::ROW_W-1:0]  wr_row_reg;

    logic                        clear_reg;
    logic                        clear_next;
    logic [rbqs_pkg::ADDR_W-1:0] clear_addr_reg;
    logic [rbqs_pkg::ADDR_W-1:0] clear_addr_next;

    logic [rbqs_pkg::ROW_W-1:0]  cur_row;
    logic [rbqs_pkg::ROW_W-1:0]  upd_row;
    logic [CB-1:0]               cur_lane;
    logic [CB-1:0]               new_lane;
    logic                        upd_we;

    logic                        mem_we;
    logic [rbqs_pkg::ADDR_W-1:0] mem_waddr;
    logic [rbqs_pkg::ROW_W-1:0]  mem_wdata;

    // newest write to the same row wins over the array output
    always_comb begin
        if (wr_valid_reg && (wr_addr_reg == p_addr_reg)) begin
            cur_row = wr_row_reg;
        end else begin
            cur_row = rd_data_reg;
        end
        cur_lane = cur_row[p_lane_reg*CB +: CB];
        new_lane = (&cur_lane) ? cur_lane : cur_lane + 1'b1;
        upd_row  = cur_row;
        upd_row[p_lane_reg*CB +: CB] = new_lane;
    end

    assign lane_value = cur_lane;
    assign upd_we     = retire && p_inc_reg;
    assign clearing   = clear_reg;

    always_comb begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg) begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (&clear_addr_reg) begin
                clear_next = 1'b0;
            end
        end
    end

    always_comb begin
        if (clear_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clear_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = upd_we;
            mem_waddr = p_addr_reg;
            mem_wdata = upd_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd) begin
            p_addr_reg <= req.addr;
            p_lane_reg <= req.lane;
        end
        if (upd_we) begin
            wr_addr_reg <= p_addr_reg;
            wr_row_reg  <= upd_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_inc_reg      <= 1'b0;
            wr_valid_reg   <= 1'b0;
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end else begin
            if (req.rd) begin
                p_inc_reg <= req.inc;
            end else if (retire) begin
                p_inc_reg <= 1'b0;
            end
            if (upd_we) begin
                wr_valid_reg <= 1'b1;
            end
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/read_base_quality_statistics_unit.sv =====
// Per-read base quality statistics with a mate/set/position/quality/nucleotide
// histogram. One request enters per clock when s_ready is high: a base request
// updates the per-read tallies at once and, when asked, increments one
// histogram counter; a query request returns one counter. A result passes
// stage 1 and the output register (a counts reply only for a base that ends a
// read). The histogram lives in one synchronous memory of 65536 rows, five
// counters a row; each increment is a read in the accept cycle and a write as
// the request leaves stage 1, with the last written row forwarded so
// back-to-back hits on the same row stay exact. After reset the memory is
// cleared one row a cycle while s_ready stays low; configuration writes are
// taken at any time and must only be issued while the block is idle.
`default_nettype none
module read_base_quality_statistics_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [7:0]  s_base_char,
    input  wire logic [7:0]  s_quality_char,
    input  wire logic        s_mate,
    input  wire logic        s_read_set,
    input  wire logic        s_end_of_read,
    input  wire logic        s_into_histogram,
    input  wire logic [7:0]  s_query_position,
    input  wire logic [5:0]  s_query_quality,
    input  wire logic [2:0]  s_query_base,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_reply_kind,
    output logic [8:0]       m_read_length,
    output logic [8:0]       m_above_cutoff_count,
    output logic [8:0]       m_q20_count,
    output logic [8:0]       m_q30_count,
    output logic [8:0]       m_gc_total,
    output logic [8:0]       m_n_total,
    output logic             m_too_long,
    output logic [31:0]      m_histogram_value
);

    localparam int CNT_W   = rbqs_pkg::CNT_W;
    localparam int COUNT_W = rbqs_pkg::COUNT_W;

    // configuration registers
    logic [6:0] quality_offset_reg;
    logic [5:0] quality_cutoff_reg;
    logic       paired_mode_reg;

    // running tallies of the current read
    logic [CNT_W-1:0] pos_cnt_reg,  pos_cnt_next;
    logic [CNT_W-1:0] cut_cnt_reg,  cut_cnt_next;
    logic [CNT_W-1:0] q20_cnt_reg,  q20_cnt_next;
    logic [CNT_W-1:0] q30_cnt_reg,  q30_cnt_next;
    logic [CNT_W-1:0] gc_cnt_reg,   gc_cnt_next;
    logic [CNT_W-1:0] n_cnt_reg,    n_cnt_next;
    logic             overflow_reg, overflow_next;

    // stage 1: request waiting on the histogram read
    logic             p1_valid_reg;
    logic             p1_result_reg;
    logic             p1_kind_reg;
    logic             p1_query_ok_reg;
    logic [CNT_W-1:0] p1_len_reg;
    logic [CNT_W-1:0] p1_cut_reg;
    logic [CNT_W-1:0] p1_q20_reg;
    logic [CNT_W-1:0] p1_q30_reg;
    logic [CNT_W-1:0] p1_gc_reg;
    logic [CNT_W-1:0] p1_n_reg;
    logic             p1_long_reg;

    // output register
    logic             m_valid_reg;
    logic             m_kind_reg;
    logic [8:0]       m_len_reg;
    logic [8:0]       m_cut_reg;
    logic [8:0]       m_q20_reg;
    logic [8:0]       m_q30_reg;
    logic [8:0]       m_gc_reg;
    logic [8:0]       m_n_reg;
    logic             m_long_reg;
    logic [31:0]      m_value_reg;

    logic                                   accept;
    logic                                   is_base;
    logic                                   is_query;
    logic                                   in_range;
    logic                                   p1_advance;
    logic                                   clearing;
    logic                                   query_ok;
    logic signed [rbqs_pkg::SCORE_W-1:0]    score;
    logic [rbqs_pkg::QUAL_W-1:0]            qual_idx;
    rbqs_pkg::nuc_t                         nuc;
    logic                                   hist_inc;
    rbqs_pkg::hist_req_t                    hreq;
    logic [rbqs_pkg::COUNTER_BITS-1:0]      lane_value;

    assign cfg_ready = 1'b1;

    // stage 1 leaves when it has nothing to show or the output slot frees up
    assign p1_advance = p1_valid_reg && (!p1_result_reg || !m_valid_reg || m_ready);
    assign s_ready    = !clearing && (!p1_valid_reg || p1_advance);
    assign accept     = s_valid && s_ready;
    assign is_base    = accept && (s_action == rbqs_pkg::ACT_BASE);
    assign is_query   = accept && (s_action == rbqs_pkg::ACT_QUERY);
    assign in_range   = (32'(pos_cnt_reg) < rbqs_pkg::MAX_POSITIONS);

    // quality score, signed, and its clamped histogram index
    assign score = $signed({1'b0, s_quality_char}) - $signed({2'b00, quality_offset_reg});
    assign nuc   = rbqs_pkg::nucleotide_code(s_base_char);

    always_comb begin
        if (score < 0) begin
            qual_idx = '0;
        end else if (score > rbqs_pkg::QUAL_MAX_S) begin
            qual_idx = rbqs_pkg::QUAL_W'(rbqs_pkg::QUALITY_LEVELS - 1);
        end else begin
            qual_idx = score[rbqs_pkg::QUAL_W-1:0];
        end
    end

    // out-of-range query index reads back as zero
    assign query_ok = (32'(s_query_position) < rbqs_pkg::MAX_POSITIONS)
                   && (32'(s_query_quality) < rbqs_pkg::QUALITY_LEVELS)
                   && (32'(s_query_base) < rbqs_pkg::NUCLEOTIDES);

    // mate 1 only lands in the histogram in paired mode; unknown letters never
    assign hist_inc = is_base && in_range && s_into_histogram
                   && (nuc != rbqs_pkg::NUC_OTHER)
                   && (!s_mate || paired_mode_reg);

    always_comb begin
        hreq.rd   = hist_inc || is_query;
        hreq.inc  = hist_inc;
        if (is_query) begin
            hreq.addr = {s_mate, s_read_set,
                         rbqs_pkg::POS_W'(s_query_position),
                         rbqs_pkg::QUAL_W'(s_query_quality)};
            hreq.lane = query_ok ? s_query_base : rbqs_pkg::NUC_A;
        end else begin
            hreq.addr = {s_mate, s_read_set,
                         pos_cnt_reg[rbqs_pkg::POS_W-1:0], qual_idx};
            hreq.lane = nuc;
        end
    end

    rbqs_hist u_hist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (hreq),
        .retire     (p1_advance),
        .lane_value (lane_value),
        .clearing   (clearing)
    );

    // tally update; bases past the position limit only mark overflow
    always_comb begin
        pos_cnt_next  = pos_cnt_reg;
        cut_cnt_next  = cut_cnt_reg;
        q20_cnt_next  = q20_cnt_reg;
        q30_cnt_next  = q30_cnt_reg;
        gc_cnt_next   = gc_cnt_reg;
        n_cnt_next    = n_cnt_reg;
        overflow_next = overflow_reg;
        if (is_base) begin
            if (!in_range) begin
                overflow_next = 1'b1;
            end else begin
                pos_cnt_next = pos_cnt_reg + 1'b1;
                if (score >= $signed({3'b000, quality_cutoff_reg})) begin
                    cut_cnt_next = cut_cnt_reg + 1'b1;
                end
                if (score >= rbqs_pkg::Q20_LEVEL) begin
                    q20_cnt_next = q20_cnt_reg + 1'b1;
                end
                if (score >= rbqs_pkg::Q30_LEVEL) begin
                    q30_cnt_next = q30_cnt_reg + 1'b1;
                end
                if ((nuc == rbqs_pkg::NUC_C) || (nuc == rbqs_pkg::NUC_G)) begin
                    gc_cnt_next = gc_cnt_reg + 1'b1;
                end
                if (nuc == rbqs_pkg::NUC_N) begin
                    n_cnt_next = n_cnt_reg + 1'b1;
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quality_offset_reg <= 7'd33;
            quality_cutoff_reg <= 6'd20;
            paired_mode_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rbqs_pkg::CFG_QUALITY_OFFSET: quality_offset_reg <= cfg_data;
                rbqs_pkg::CFG_QUALITY_CUTOFF: quality_cutoff_reg <= cfg_data[5:0];
                rbqs_pkg::CFG_PAIRED_MODE:    paired_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // tallies, cleared once the read's last base is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_cnt_reg  <= '0;
            cut_cnt_reg  <= '0;
            q20_cnt_reg  <= '0;
            q30_cnt_reg  <= '0;
            gc_cnt_reg   <= '0;
            n_cnt_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (is_base && s_end_of_read) begin
            pos_cnt_reg  <= '0;
            cut_cnt_reg  <= '0;
            q20_cnt_reg  <= '0;
            q30_cnt_reg  <= '0;
            gc_cnt_reg   <= '0;
            n_cnt_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            pos_cnt_reg  <= pos_cnt_next;
            cut_cnt_reg  <= cut_cnt_next;
            q20_cnt_reg  <= q20_cnt_next;
            q30_cnt_reg  <= q30_cnt_next;
            gc_cnt_reg   <= gc_cnt_next;
            n_cnt_reg    <= n_cnt_next;
            overflow_reg <= overflow_next;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_kind_reg     <= is_query ? rbqs_pkg::REPLY_HIST : rbqs_pkg::REPLY_COUNTS;
            p1_query_ok_reg <= query_ok;
            p1_len_reg      <= pos_cnt_next;
            p1_cut_reg      <= cut_cnt_next;
            p1_q20_reg      <= q20_cnt_next;
            p1_q30_reg      <= q30_cnt_next;
            p1_gc_reg       <= gc_cnt_next;
            p1_n_reg        <= n_cnt_next;
            p1_long_reg     <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p1_result_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg  <= 1'b1;
            p1_result_reg <= is_query || s_end_of_read;
        end else if (p1_advance) begin
            p1_valid_reg  <= 1'b0;
            p1_result_reg <= 1'b0;
        end
    end

    // output register; each reply kind zeroes the other kind's fields
    always_ff @(posedge aclk) begin
        if (p1_advance && p1_result_reg) begin
            m_kind_reg <= p1_kind_reg;
            if (p1_kind_reg == rbqs_pkg::REPLY_HIST) begin
                m_len_reg   <= '0;
                m_cut_reg   <= '0;
                m_q20_reg   <= '0;
                m_q30_reg   <= '0;
                m_gc_reg    <= '0;
                m_n_reg     <= '0;
                m_long_reg  <= 1'b0;
                m_value_reg <= p1_query_ok_reg ? rbqs_pkg::VALUE_W'(lane_value) : '0;
            end else begin
                m_len_reg   <= COUNT_W'(p1_len_reg);
                m_cut_reg   <= COUNT_W'(p1_cut_reg);
                m_q20_reg   <= COUNT_W'(p1_q20_reg);
                m_q30_reg   <= COUNT_W'(p1_q30_reg);
                m_gc_reg    <= COUNT_W'(p1_gc_reg);
                m_n_reg     <= COUNT_W'(p1_n_reg);
                m_long_reg  <= p1_long_reg;
                m_value_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_advance && p1_result_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_reply_kind         = m_kind_reg;
    assign m_read_length        = m_len_reg;
    assign m_above_cutoff_count = m_cut_reg;
    assign m_q20_count          = m_q20_reg;
    assign m_q30_count          = m_q30_reg;
    assign m_gc_total           = m_gc_reg;
    assign m_n_total            = m_n_reg;
    assign m_too_long           = m_long_reg;
    assign m_histogram_value    = m_value_reg;

endmodule
`default_nettype wire

// ===== rtl/rbqs_checker.sv =====
`default_nettype none
module rbqs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [1:0]  cfg_index,
    input wire logic [6:0]  cfg_data,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_action,
    input wire logic [7:0]  s_base_char,
    input wire logic [7:0]  s_quality_char,
    input wire logic        s_mate,
    input wire logic        s_read_set,
    input wire logic        s_end_of_read,
    input wire logic        s_into_histogram,
    input wire logic [7:0]  s_query_position,
    input wire logic [5:0]  s_query_quality,
    input wire logic [2:0]  s_query_base,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_reply_kind,
    input wire logic [8:0]  m_read_length,
    input wire logic [8:0]  m_above_cutoff_count,
    input wire logic [8:0]  m_q20_count,
    input wire logic [8:0]  m_q30_count,
    input wire logic [8:0]  m_gc_total,
    input wire logic [8:0]  m_n_total,
    input wire logic        m_too_long,
    input wire logic [31:0] m_histogram_value
);

    // histogram clear pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during histogram clear");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_histogram_value)
                                && $stable(m_read_length))
        else $error("result changed while stalled");

    a_counts_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_reply_kind == rbqs_pkg::REPLY_COUNTS)
        |-> (m_histogram_value == '0) && (m_above_cutoff_count <= m_read_length)
            && (m_q30_count <= m_q20_count) && (m_q20_count <= m_read_length)
            && ((m_gc_total + m_n_total) <= m_read_length))
        else $error("inconsistent per-read counts");

    a_hist_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_reply_kind == rbqs_pkg::REPLY_HIST)
        |-> (m_read_length == '0) && !m_too_long && (m_gc_total == '0))
        else $error("histogram reply carries counts");

    a_too_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_long
        |-> (m_read_length == rbqs_pkg::COUNT_W'(rbqs_pkg::MAX_POSITIONS)))
        else $error("overflow flagged below position limit");

endmodule

bind read_base_quality_statistics_unit rbqs_checker u_rbqs_checker (.*);
`default_nettype wire

// ===== dv/read_base_quality_statistics_unit_tb.sv =====
`timescale 1ns / 100ps

module read_base_quality_statistics_unit_tb;
    import rbqs_pkg::*;

    // no accept of any kind for this long means the block is hung; the
    // clearing pass after reset alone keeps s_ready low
    localparam int WATCHDOG_LIMIT = 262144;
    // cycles to let a base request with no reply finish before a config write
    localparam int DRAIN_SLACK    = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int HIT_MEMORY     = 64;
    // letters the block knows, both cases
    localparam logic [79:0] LETTERS = "ACGTNacgtn";

    // one request on the input channel
    typedef struct packed {
        logic       action;
        logic [7:0] base_char;
        logic [7:0] quality_char;
        logic       mate;
        logic       read_set;
        logic       end_of_read;
        logic       into_histogram;
        logic [7:0] query_position;
        logic [5:0] query_quality;
        logic [2:0] query_base;
    } base_request_t;

    // one reply on the result channel, in port order
    typedef struct packed {
        logic        reply_kind;
        logic [8:0]  read_length;
        logic [8:0]  above_cutoff;
        logic [8:0]  q20;
        logic [8:0]  q30;
        logic [8:0]  gc_total;
        logic [8:0]  n_total;
        logic        too_long;
        logic [31:0] value;
    } stats_reply_t;

    typedef enum int {RX_STEADY, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic [7:0]  s_base_char;
    logic [7:0]  s_quality_char;
    logic        s_mate;
    logic        s_read_set;
    logic        s_end_of_read;
    logic        s_into_histogram;
    logic [7:0]  s_query_position;
    logic [5:0]  s_query_quality;
    logic [2:0]  s_query_base;
    logic        m_valid;
    logic        m_ready;
    logic        m_reply_kind;
    logic [8:0]  m_read_length;
    logic [8:0]  m_above_cutoff_count;
    logic [8:0]  m_q20_count;
    logic [8:0]  m_q30_count;
    logic [8:0]  m_gc_total;
    logic [8:0]  m_n_total;
    logic        m_too_long;
    logic [31:0] m_histogram_value;

    // shadow of the block: configuration, per-read tallies and the histogram
    int          qual_offset  = 33;
    int          qual_cutoff  = 20;
    logic        paired       = 1'b0;
    int          read_bases   = 0;
    int          cutoff_hits  = 0;
    int          q20_hits     = 0;
    int          q30_hits     = 0;
    int          gc_bases     = 0;
    int          n_bases      = 0;
    logic        read_overrun = 1'b0;
    logic [31:0] hist_counts [int];

    // replies still owed by the block, oldest first
    stats_reply_t  predicted_replies [$];
    // recently incremented histogram entries, kept as ready-made queries
    base_request_t hit_queries [$];

    int          mismatches         = 0;
    int          requests_sent      = 0;
    int          sender_burst_left  = 0;
    bit          offering           = 1'b0;
    int          rx_holdoff_cycles  = 0;
    int          idle_cycles        = 0;
    stats_reply_t observed;
    stats_reply_t predicted;

    read_base_quality_statistics_unit i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_action             (s_action),
        .s_base_char          (s_base_char),
        .s_quality_char       (s_quality_char),
        .s_mate               (s_mate),
        .s_read_set           (s_read_set),
        .s_end_of_read        (s_end_of_read),
        .s_into_histogram     (s_into_histogram),
        .s_query_position     (s_query_position),
        .s_query_quality      (s_query_quality),
        .s_query_base         (s_query_base),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_reply_kind         (m_reply_kind),
        .m_read_length        (m_read_length),
        .m_above_cutoff_count (m_above_cutoff_count),
        .m_q20_count          (m_q20_count),
        .m_q30_count          (m_q30_count),
        .m_gc_total           (m_gc_total),
        .m_n_total            (m_n_total),
        .m_too_long           (m_too_long),
        .m_histogram_value    (m_histogram_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic nuc_t letter_to_lane(input logic [7:0] ch);
        case (ch)
            "A", "a": return NUC_A;
            "C", "c": return NUC_C;
            "G", "g": return NUC_G;
            "T", "t": return NUC_T;
            "N", "n": return NUC_N;
            default:  return NUC_OTHER;
        endcase
    endfunction

    // flat counter number for mate, set, position, quality bin and lane
    function automatic int hist_key(input logic mate, input logic read_set, input int pos,
                                    input int qbin, input int lane);
        int sel;
        sel = 2 * mate + read_set;
        return ((sel * MAX_POSITIONS + pos) * QUALITY_LEVELS + qbin) * NUCLEOTIDES + lane;
    endfunction

    // apply one accepted request to the shadow state, queue any reply it owes
    function automatic void account_request(input base_request_t r);
        stats_reply_t reply;
        base_request_t seen;
        nuc_t lane;
        int qchar;
        int score;
        int qbin;
        int key;
        reply = '0;
        if (r.action == ACT_QUERY) begin
            // lanes past N (and any index past the table) read as zero
            reply.reply_kind = REPLY_HIST;
            if (r.query_position < MAX_POSITIONS && r.query_quality < QUALITY_LEVELS &&
                r.query_base < NUCLEOTIDES) begin
                key = hist_key(r.mate, r.read_set, r.query_position, r.query_quality,
                               r.query_base);
                if (hist_counts.exists(key))
                    reply.value = hist_counts[key];
            end
            predicted_replies.push_back(reply);
            return;
        end

        if (read_bases >= MAX_POSITIONS) begin
            // past the position limit only the overrun flag moves
            read_overrun = 1'b1;
        end else begin
            qchar = r.quality_char;
            score = qchar - qual_offset;
            lane  = letter_to_lane(r.base_char);
            if (score >= qual_cutoff) cutoff_hits++;
            if (score >= 20) q20_hits++;
            if (score >= 30) q30_hits++;
            if (lane == NUC_C || lane == NUC_G) gc_bases++;
            if (lane == NUC_N) n_bases++;
            if (r.into_histogram && lane != NUC_OTHER && (!r.mate || paired)) begin
                if (score < 0)
                    qbin = 0;
                else if (score > QUALITY_LEVELS - 1)
                    qbin = QUALITY_LEVELS - 1;
                else
                    qbin = score;
                key = hist_key(r.mate, r.read_set, read_bases, qbin, lane);
                if (!hist_counts.exists(key))
                    hist_counts[key] = '0;
                if (hist_counts[key] != '1)
                    hist_counts[key]++;
                seen                = '0;
                seen.action         = ACT_QUERY;
                seen.mate           = r.mate;
                seen.read_set       = r.read_set;
                seen.query_position = read_bases;
                seen.query_quality  = qbin;
                seen.query_base     = lane;
                hit_queries.push_back(seen);
                if (hit_queries.size() > HIT_MEMORY)
                    void'(hit_queries.pop_front());
            end
            read_bases++;
        end

        if (!r.end_of_read)
            return;
        reply.reply_kind   = REPLY_COUNTS;
        reply.read_length  = read_bases;
        reply.above_cutoff = cutoff_hits;
        reply.q20          = q20_hits;
        reply.q30          = q30_hits;
        reply.gc_total     = gc_bases;
        reply.n_total      = n_bases;
        reply.too_long     = read_overrun;
        predicted_replies.push_back(reply);
        read_bases   = 0;
        cutoff_hits  = 0;
        q20_hits     = 0;
        q30_hits     = 0;
        gc_bases     = 0;
        n_bases      = 0;
        read_overrun = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // request construction
    // ------------------------------------------------------------------

    // every field random, so every bit of every port sees both values
    function automatic base_request_t random_request();
        base_request_t r;
        r.action         = $urandom_range(0, 1);
        r.base_char      = $urandom_range(0, 255);
        r.quality_char   = $urandom_range(0, 255);
        r.mate           = $urandom_range(0, 1);
        r.read_set       = $urandom_range(0, 1);
        r.end_of_read    = $urandom_range(0, 1);
        r.into_histogram = $urandom_range(0, 1);
        r.query_position = $urandom_range(0, 255);
        r.query_quality  = $urandom_range(0, 63);
        r.query_base     = $urandom_range(0, 7);
        return r;
    endfunction

    function automatic base_request_t base_item(input logic [7:0] ch, input logic [7:0] qual,
                                                input logic mate, input logic read_set,
                                                input logic last, input logic into_hist);
        base_request_t r;
        r                = '0;
        r.action         = ACT_BASE;
        r.base_char      = ch;
        r.quality_char   = qual;
        r.mate           = mate;
        r.read_set       = read_set;
        r.end_of_read    = last;
        r.into_histogram = into_hist;
        return r;
    endfunction

    function automatic base_request_t query_item(input logic mate, input logic read_set,
                                                 input logic [7:0] pos, input logic [5:0] qbin,
                                                 input logic [2:0] lane);
        base_request_t r;
        r                = '0;
        r.action         = ACT_QUERY;
        r.mate           = mate;
        r.read_set       = read_set;
        r.query_position = pos;
        r.query_quality  = qbin;
        r.query_base     = lane;
        return r;
    endfunction

    // quality characters mostly around the live offset so all thresholds matter
    function automatic logic [7:0] random_quality();
        int q;
        logic [7:0] ch;
        if ($urandom_range(0, 4) == 0) begin
            ch = $urandom_range(0, 255);
        end else begin
            q = qual_offset + $urandom_range(0, 75) - 5;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            ch = q;
        end
        return ch;
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] ch;
        if ($urandom_range(0, 9) == 0)
            ch = $urandom_range(0, 255);
        else
            ch = LETTERS[8 * $urandom_range(0, 9) +: 8];
        return ch;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    task automatic drop_valid();
        if (offering) begin
            s_valid  <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // offer one request, wait for its handshake, then maybe leave a gap
    task automatic send_request(input base_request_t r);
        int gap;
        if (!offering) begin
            s_valid  <= 1'b1;
            offering = 1'b1;
        end
        s_action         <= r.action;
        s_base_char      <= r.base_char;
        s_quality_char   <= r.quality_char;
        s_mate           <= r.mate;
        s_read_set       <= r.read_set;
        s_end_of_read    <= r.end_of_read;
        s_into_histogram <= r.into_histogram;
        s_query_position <= r.query_position;
        s_query_quality  <= r.query_quality;
        s_query_base     <= r.query_base;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        account_request(r);
        requests_sent++;
        // bursts of random length; now and then a long one with no gaps at all
        if (sender_burst_left > 0) begin
            sender_burst_left--;
        end else begin
            sender_burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                             : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                drop_valid();
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // pause the sender until the block owes nothing and has settled
    task automatic wait_for_replies();
        drop_valid();
        while (predicted_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    // register write; valid is left up so back-to-back writes need no toggle
    task automatic write_register(input cfg_index_t idx, input logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_QUALITY_OFFSET: qual_offset = value;
            CFG_QUALITY_CUTOFF: qual_cutoff = value[5:0];
            CFG_PAIRED_MODE:    paired      = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [6:0] offset, input logic [6:0] cutoff,
                                 input logic [6:0] pair_bit);
        wait_for_replies();
        write_register(CFG_QUALITY_OFFSET, offset);
        write_register(CFG_QUALITY_CUTOFF, cutoff);
        write_register(CFG_PAIRED_MODE, pair_bit);
        cfg_valid <= 1'b0;
    endtask

    // one well-formed read with random content, end mark on its last base
    task automatic send_read(input int length, input logic mate, input logic read_set);
        base_request_t r;
        for (int i = 0; i < length; i++) begin
            r                = random_request();
            r.action         = ACT_BASE;
            r.base_char      = random_letter();
            r.quality_char   = random_quality();
            r.mate           = mate;
            r.read_set       = read_set;
            r.into_histogram = ($urandom_range(0, 7) != 0);
            r.end_of_read    = (i == length - 1);
            send_request(r);
            // a query in the middle of a read must not disturb its tallies
            if (i != length - 1 && $urandom_range(0, 15) == 0)
                send_histogram_query(1'b1);
        end
    endtask

    // query a recently hit entry, or any index at all
    task automatic send_histogram_query(input bit from_hits);
        base_request_t r;
        base_request_t pick;
        r        = random_request();
        r.action = ACT_QUERY;
        if (from_hits && hit_queries.size() != 0) begin
            pick             = hit_queries[$urandom_range(0, hit_queries.size() - 1)];
            r.mate           = pick.mate;
            r.read_set       = pick.read_set;
            r.query_position = pick.query_position;
            r.query_quality  = pick.query_quality;
            r.query_base     = pick.query_base;
        end
        send_request(r);
    endtask

    task automatic run_random_traffic(input int item_count);
        int stop_at;
        int pick;
        int length;
        stop_at = requests_sent + item_count;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // mostly short reads, a few longer ones
                length = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8);
                send_read(length, $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (pick < 80) begin
                send_histogram_query(1'b1);
            end else if (pick < 88) begin
                send_histogram_query(1'b0);
            end else if (pick < 97) begin
                // noise: may open or cut a read anywhere
                send_request(random_request());
            end else begin
                wait_for_replies();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset configuration: offset 33, cutoff 20, paired mode off
    task automatic test_directed_cases();
        // one read across every letter, threshold edges and both clamp ends
        send_request(base_item("A", 8'd33,  0, 0, 0, 1));  // score 0
        send_request(base_item("c", 8'd52,  0, 0, 0, 1));  // just below 20
        send_request(base_item("G", 8'd53,  0, 0, 0, 1));  // exactly 20
        send_request(base_item("t", 8'd62,  0, 0, 0, 1));  // just below 30
        send_request(base_item("T", 8'd63,  0, 0, 0, 1));  // exactly 30
        send_request(base_item("N", 8'hFF,  0, 0, 0, 1));  // clamps to top bin
        send_request(base_item("x", 8'h00,  0, 0, 0, 1));  // unknown letter, negative
        send_request(base_item("n", 8'd10,  0, 0, 1, 1));  // negative, bin 0, end
        // mate 1 without paired mode counts but stays out of the histogram
        send_request(base_item("G", 8'd73,  1, 1, 1, 1));
        // single-base read, all-ones characters, no histogram
        send_request(base_item(8'hFF, 8'hFF, 0, 1, 1, 0));
        send_request(query_item(0, 0, 8'd0,   6'd0,  NUC_A));
        send_request(query_item(0, 0, 8'd1,   6'd0,  NUC_C));
        send_request(query_item(0, 0, 8'd5,   6'd63, NUC_N));
        send_request(query_item(0, 0, 8'd7,   6'd0,  NUC_N));
        send_request(query_item(1, 1, 8'd0,   6'd40, NUC_G));
        send_request(query_item(0, 0, 8'd6,   6'd0,  NUC_OTHER));
        send_request(query_item(0, 0, 8'd0,   6'd0,  '1));  // all ones, past every lane
        send_request(query_item(1, 1, 8'd255, 6'd63, NUC_T));
        // query in the middle of a read
        send_request(base_item("g", 8'd43,  0, 0, 0, 1));
        send_request(query_item(0, 0, 8'd0,   6'd0,  NUC_A));
        send_request(base_item("C", 8'd126, 0, 0, 1, 1));
    endtask

    // several register settings including both extremes of each field
    task automatic test_register_settings();
        apply_setting(7'd0,   7'd0,   7'd1);
        run_random_traffic(110);
        apply_setting(7'd127, 7'h7F, 7'd0);  // cutoff keeps its low six bits
        run_random_traffic(110);
        apply_setting(7'd33,  7'd63,  7'd1);
        run_random_traffic(110);
        apply_setting(7'd64,  7'd30,  7'h7E);  // paired mode keeps bit 0 only
        run_random_traffic(110);
        apply_setting($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
        run_random_traffic(110);
    endtask

    // a read filling every position, then one running past the limit
    task automatic test_position_limit();
        apply_setting(7'd33, 7'd20, 7'd1);
        send_read(MAX_POSITIONS, 1'b0, $urandom_range(0, 1));
        send_request(hit_queries[hit_queries.size() - 1]);
        send_read(MAX_POSITIONS + $urandom_range(1, 4), $urandom_range(0, 1),
                  $urandom_range(0, 1));
        send_request(hit_queries[hit_queries.size() - 1]);
        send_histogram_query(1'b1);
    endtask

    // receiver holds off while the sender keeps pushing, so the block backs up;
    // repeated single-base reads also hit one histogram row back to back
    task automatic test_output_holdoff();
        wait_for_replies();
        sender_burst_left = 1000;
        rx_holdoff_cycles = 150;
        for (int i = 0; i < 40; i++) begin
            if (i % 4 == 3)
                send_histogram_query(1'b1);
            else
                send_request(base_item("G", 8'd73, 0, 0, 1, 1));
        end
        sender_burst_left = 0;
        send_request(hit_queries[hit_queries.size() - 1]);
    endtask

    task automatic test_random_traffic();
        run_random_traffic(160);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    function automatic string reply_text(input stats_reply_t p);
        return $sformatf("kind=%0d len=%0d cut=%0d q20=%0d q30=%0d gc=%0d n=%0d long=%0d val=%0d",
                         p.reply_kind, p.read_length, p.above_cutoff, p.q20, p.q30,
                         p.gc_total, p.n_total, p.too_long, p.value);
    endfunction

    // receiver stalls on patterns that are picked anew at random
    initial begin
        rx_pattern_t rx_mode;
        int          rx_left;
        int          rx_tick;
        int          hold;
        rx_mode = RX_STEADY;
        rx_left = 0;
        rx_tick = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            rx_tick++;
            if (rx_holdoff_cycles != 0) begin
                // long hold-off, counted here
                hold              = rx_holdoff_cycles;
                rx_holdoff_cycles = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end else begin
                if (rx_left == 0) begin
                    rx_mode = rx_pattern_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(20, 120);
                end
                rx_left--;
                case (rx_mode)
                    RX_STEADY:   m_ready <= 1'b1;
                    RX_COIN:     m_ready <= ($urandom_range(0, 1) == 1);
                    RX_PERIODIC: m_ready <= (rx_tick % 5 != 2);
                    default:     m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // every accepted reply is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            observed = {m_reply_kind, m_read_length, m_above_cutoff_count, m_q20_count,
                        m_q30_count, m_gc_total, m_n_total, m_too_long, m_histogram_value};
            if (predicted_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("reply with nothing pending: %s", reply_text(observed));
            end else begin
                predicted = predicted_replies.pop_front();
                if (observed !== predicted) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("reply mismatch at %0t", $realtime);
                        $display("  expected %s", reply_text(predicted));
                        $display("  actual   %s", reply_text(observed));
                    end
                end
            end
        end
    end

    // watchdog: ends the run if no channel moves for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired, %0d replies still pending", predicted_replies.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn          <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= CFG_QUALITY_OFFSET;
        cfg_data         <= '0;
        s_valid          <= 1'b0;
        s_action         <= ACT_BASE;
        s_base_char      <= '0;
        s_quality_char   <= '0;
        s_mate           <= 1'b0;
        s_read_set       <= 1'b0;
        s_end_of_read    <= 1'b0;
        s_into_histogram <= 1'b0;
        s_query_position <= '0;
        s_query_quality  <= '0;
        s_query_base     <= NUC_A;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // the first request waits out the histogram clearing pass on s_ready
        test_directed_cases();
        test_register_settings();
        test_position_limit();
        test_output_holdoff();
        test_random_traffic();

        wait_for_replies();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatching replies", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rbqs_pkg.sv
rtl/rbqs_hist.sv
rtl/read_base_quality_statistics_unit.sv
rtl/rbqs_checker.sv
dv/read_base_quality_statistics_unit_tb.sv
